>>> design/indexed_ordered_list_defines.svh
// assertion macros for the indexed ordered list
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

`define IOL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("indexed_ordered_list assertion failed");

`define IOL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("indexed_ordered_list reset assertion failed");

`else

`define IOL_ASSERT(lbl, prop)

`define IOL_ASSERT_RST(lbl, prop)

`endif

`endif

>>> design/iol_pkg.sv
// shared types and constants of the indexed ordered list
package iol_pkg;

  localparam int POS_W       = 4;
  localparam int LEN_W       = 5;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 5;
  localparam int MODE_W      = 3;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 40;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT     = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_CUT        = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e              mode;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] window_length;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
    status_e          status;
  } res_t;

endpackage

>>> design/iol_mem.sv
// single write, single registered read entry store
module iol_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int AW     = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/iol_ctrl.sv
// request sequencer: range checks and element moves through the store port
module iol_ctrl #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  iol_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output iol_pkg::res_t res_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > iol_pkg::LEN_W) ? CW : iol_pkg::LEN_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_WRITE  = 6'b000100,
    S_PLACE  = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             held_q, held_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             src_q, src_d;
  logic [AW-1:0]             dst_q, dst_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic                      up_q, up_d;
  logic                      ins_q, ins_d;
  logic [DATA_W-1:0]         val_q, val_d;
  logic [iol_pkg::VAL_W-1:0] rd_q, rd_d;
  iol_pkg::status_e          st_q, st_d;

  logic              accept;
  logic [EW-1:0]     pos_e, len_e, held_e, depth_e;
  logic              full, pos_ok, cut_ok;
  logic [AW-1:0]     pos_a, ins_a;
  logic [CW-1:0]     ins_cnt;
  logic [63:0]       vin_w, rdata_w;
  logic [DATA_W-1:0] val_w;
  logic [15:0]       held16;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  assign pos_e   = EW'(req_i.position);
  assign len_e   = EW'(req_i.window_length);
  assign held_e  = EW'(held_q);
  assign depth_e = EW'(DEPTH);
  assign full    = (held_e == depth_e);
  assign pos_ok  = (pos_e < held_e);
  assign cut_ok  = pos_ok && ((pos_e + len_e) <= held_e);
  assign pos_a   = pos_e[AW-1:0];

  assign vin_w   = 64'(req_i.value);
  assign val_w   = vin_w[DATA_W-1:0];
  assign rdata_w = 64'(rdata);

  // insert point and number of elements moved up for push front and insert
  assign ins_a   = (req_i.mode == iol_pkg::OP_PUSH_FRONT) ? '0 : pos_a;
  assign ins_cnt = held_q - CW'(ins_a);

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pos_d   = pos_q;
    up_d    = up_q;
    ins_d   = ins_q;
    val_d   = val_q;
    rd_d    = rd_q;
    st_d    = st_q;
    we      = 1'b0;
    waddr   = dst_q;
    wdata   = rdata;
    re      = 1'b0;
    raddr   = src_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_d    = '0;
          st_d    = iol_pkg::ST_DONE;
          val_d   = val_w;
          state_d = S_DONE;
          case (req_i.mode)
            iol_pkg::OP_PUSH_BACK: begin
              if (full) begin
                st_d = iol_pkg::ST_FULL;
              end else begin
                we     = 1'b1;
                waddr  = held_q[AW-1:0];
                wdata  = val_w;
                held_d = held_q + CW'(1);
              end
            end
            iol_pkg::OP_PUSH_FRONT, iol_pkg::OP_INSERT: begin
              if ((req_i.mode == iol_pkg::OP_INSERT) && !pos_ok) begin
                st_d = iol_pkg::ST_RANGE;
              end else if (full) begin
                st_d = iol_pkg::ST_FULL;
              end else begin
                held_d = held_q + CW'(1);
                pos_d  = ins_a;
                cnt_d  = ins_cnt;
                src_d  = AW'(held_q - CW'(1));
                dst_d  = held_q[AW-1:0];
                up_d   = 1'b0;
                ins_d  = 1'b1;
                state_d = (ins_cnt == '0) ? S_PLACE : S_READ;
              end
            end
            iol_pkg::OP_REMOVE: begin
              if (!pos_ok) begin
                st_d = iol_pkg::ST_RANGE;
              end else begin
                held_d  = held_q - CW'(1);
                cnt_d   = held_q - CW'(1) - CW'(pos_a);
                src_d   = pos_a + AW'(1);
                dst_d   = pos_a;
                up_d    = 1'b1;
                ins_d   = 1'b0;
                state_d = ((held_q - CW'(1)) == CW'(pos_a)) ? S_DONE : S_READ;
              end
            end
            iol_pkg::OP_READ: begin
              if (!pos_ok) begin
                st_d = iol_pkg::ST_RANGE;
              end else begin
                re      = 1'b1;
                raddr   = pos_a;
                state_d = S_RDWAIT;
              end
            end
            iol_pkg::OP_CLEAR: begin
              held_d = '0;
            end
            iol_pkg::OP_CUT: begin
              if (!cut_ok) begin
                st_d = iol_pkg::ST_RANGE;
              end else begin
                held_d  = len_e[CW-1:0];
                cnt_d   = len_e[CW-1:0];
                src_d   = pos_a;
                dst_d   = '0;
                up_d    = 1'b1;
                ins_d   = 1'b0;
                state_d = (len_e == '0) ? S_DONE : S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        re      = 1'b1;
        raddr   = src_q;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = dst_q;
        wdata = rdata;
        cnt_d = cnt_q - CW'(1);
        src_d = up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
        dst_d = up_q ? (dst_q + AW'(1)) : (dst_q - AW'(1));
        if (cnt_q == CW'(1)) begin
          state_d = ins_q ? S_PLACE : S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_PLACE: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = val_q;
        state_d = S_DONE;
      end
      S_RDWAIT: begin
        rd_d    = rdata_w[iol_pkg::VAL_W-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    src_q <= src_d;
    dst_q <= dst_d;
    pos_q <= pos_d;
    up_q  <= up_d;
    ins_q <= ins_d;
    val_q <= val_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
  end

  iol_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .AW     (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign held16      = 16'(held_q);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.read_value = rd_q;
    res_o.count      = held16[iol_pkg::CNT_W-1:0];
    res_o.status     = st_q;
  end

endmodule

>>> design/indexed_ordered_list.sv
// top level of the indexed ordered list with stream ports and output register
//
// one request beat in on the slave side, one result beat out on the master side
// s_axis_tuser selects the operation: push back, push front, insert, remove,
// read, clear or cut; s_axis_tdata carries position, window length and value
// m_axis_tdata returns the read value and the element count, m_axis_tuser the status
// the block takes one request at a time; s_axis_tready is high only when idle
// steps from accepted beat to m_axis_tvalid:
//   push back, clear, range or full refusal: straight to the result
//   read: a registered store read, then the result
//   remove and cut: a read and a write per element moved, then the result
//   push front and insert: a read and a write per element moved up, then the value is placed
// each element move is one read and one write on the entry store, which has one write and one read port
// s_axis_tready rises in the cycle after the result enters the output register,
// so a stalled master side does not hold back one further request
// reset empties the list and drops any pending result; entries keep no reset value
module indexed_ordered_list #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // position [3:0], window_length [8:4], value [40:9], zero fill above
  input  logic [iol_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // mode [2:0]
  input  logic [iol_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_value [31:0], count [36:32], zero fill above
  output logic [iol_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [1:0]                        m_axis_tuser
);

  `include "indexed_ordered_list_defines.svh"

  iol_pkg::req_t req;
  iol_pkg::res_t res, out_q;
  logic          res_valid, res_ready;
  logic          out_valid_q;

  always_comb begin
    req.mode          = iol_pkg::op_e'(s_axis_tuser);
    req.position      = s_axis_tdata[3:0];
    req.window_length = s_axis_tdata[8:4];
    req.value         = s_axis_tdata[40:9];
  end

  iol_ctrl #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = iol_pkg::M_TDATA_W'({out_q.count, out_q.read_value});
  assign m_axis_tuser  = out_q.status;

  // busy right after a request beat
  `IOL_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // a refused push only happens on a full list
  `IOL_ASSERT(a_full_count, (m_axis_tvalid && (out_q.status == iol_pkg::ST_FULL)) |->
    (out_q.count == iol_pkg::CNT_W'(DEPTH)))
  // a pending result is kept until the master side takes it
  `IOL_ASSERT(a_hold_result, (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(out_q)))
  // nothing is offered once reset has been sampled low
  `IOL_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule
